### hw/rtl/knps_pkg.sv
// ----------------------------------------------------------------------------
// knps_pkg
// Shared types and constants of the nearest point selection block: field
// widths, the distance limit, opcodes, controller states and the command and
// status words between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package knps_pkg;

   localparam int COUNT_W = 11;
   localparam int INDEX_W = 10;
   localparam int COORD_W = 16;
   localparam int POINT_W = 3 * COORD_W;
   localparam int DIST_W = 16;
   localparam int RANK_W = 3;
   localparam int DSQ_W = 32;
   localparam int SUM_W = DSQ_W + 2;
   localparam int ROOT_STEPS = DIST_W;
   localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);

   // 9.0 in Q4.28, the square of the distance limit of 3.0.
   localparam logic [DSQ_W-1:0] LIMIT_SQ = 32'h9000_0000;

   typedef enum logic [0:0] {
      OP_LOAD = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_QUERY_READ,
      ST_QUERY_LATCH,
      ST_SCAN,
      ST_DRAIN,
      ST_RANK,
      ST_ROOT,
      ST_RESULT_LOAD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic mem_write;
      logic mem_read;
      logic list_clear;
      logic query_latch;
      logic scan_valid;
      logic root_start;
      logic root_step;
      logic result_load;
   } cmd_type;

   typedef struct packed {
      logic pipe_empty;
      logic sel_found;
   } status_type;

endpackage

`default_nettype wire

### hw/rtl/knps_ram.sv
// ----------------------------------------------------------------------------
// knps_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module knps_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### hw/rtl/knps_datapath.sv
// ----------------------------------------------------------------------------
// knps_datapath
// Point store, distance pipeline, sorted neighbour list, bit-serial square
// root and the result word register.
// ----------------------------------------------------------------------------
`default_nettype none

module knps_datapath #(
   parameter int MAX_POINTS = 1024,
   parameter int NEIGHBOURS = 6
) (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire knps_pkg::cmd_type                            cmd,
   output knps_pkg::status_type                              status,
   input  wire logic [$clog2(MAX_POINTS)-1:0]                mem_addr,
   input  wire logic [knps_pkg::COUNT_W-1:0]                 scan_index,
   input  wire logic [((NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1)-1:0] rank,
   input  wire logic [knps_pkg::INDEX_W-1:0]                 req_point_index,
   input  wire logic signed [knps_pkg::COORD_W-1:0]          req_coord_x,
   input  wire logic signed [knps_pkg::COORD_W-1:0]          req_coord_y,
   input  wire logic signed [knps_pkg::COORD_W-1:0]          req_coord_z,
   output logic [knps_pkg::RANK_W-1:0]                       rsp_rank,
   output logic                                              rsp_found,
   output logic [knps_pkg::INDEX_W-1:0]                      rsp_neighbour_index,
   output logic [knps_pkg::DIST_W-1:0]                       rsp_neighbour_distance,
   output logic                                              rsp_last
);

   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int RW = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;
   localparam int CW = knps_pkg::COUNT_W;
   localparam int XW = knps_pkg::COORD_W;
   localparam int DW = knps_pkg::DSQ_W;
   localparam int SW = knps_pkg::SUM_W;
   localparam int TW = knps_pkg::DIST_W;
   localparam int REM_W = TW + 1;

   logic [knps_pkg::POINT_W-1:0] rd_data;

   knps_ram #(
      .WIDTH (knps_pkg::POINT_W),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.mem_write),
      .wr_addr (ADDR_W'(req_point_index)),
      .wr_data ({req_coord_z, req_coord_y, req_coord_x}),
      .rd_en   (cmd.mem_read),
      .rd_addr (mem_addr),
      .rd_data (rd_data)
   );

   // Coordinates of the queried point.
   logic [XW-1:0] q_ff [3];

   always_ff @(posedge clock) begin
      if (cmd.query_latch) begin
         q_ff[0] <= rd_data[XW-1:0];
         q_ff[1] <= rd_data[2*XW-1:XW];
         q_ff[2] <= rd_data[3*XW-1:2*XW];
      end
   end

   // Distance pipeline: read data, absolute differences, squares, sum.
   logic          v1_ff, v2_ff, v3_ff, v4_ff;
   logic [CW-1:0] j1_ff, j2_ff, j3_ff, j4_ff;
   logic [XW-1:0] ad_ff [3];
   logic [XW-1:0] ad_in [3];
   logic [DW-1:0] sq_ff [3];
   logic [SW-1:0] sum_ff;

   always_comb begin
      logic [XW:0] d;
      logic [XW-1:0] p;
      for (int i = 0; i < 3; i++) begin
         p = rd_data[i*XW +: XW];
         d = {p[XW-1], p} - {q_ff[i][XW-1], q_ff[i]};
         ad_in[i] = d[XW] ? XW'(-d) : d[XW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.scan_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      j1_ff <= scan_index;
      j2_ff <= j1_ff;
      j3_ff <= j2_ff;
      j4_ff <= j3_ff;
      for (int i = 0; i < 3; i++) begin
         ad_ff[i] <= ad_in[i];
         sq_ff[i] <= {{(DW-XW){1'b0}}, ad_ff[i]} * {{(DW-XW){1'b0}}, ad_ff[i]};
      end
      sum_ff <= SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]);
   end

   // Sorted neighbour list. The list is ascending, so the less-than flags
   // form a thermometer code and the first set flag is the insertion slot.
   // Strict comparison keeps an earlier index ahead of a later equal one.
   logic [DW-1:0]         best_d_ff [NEIGHBOURS];
   logic [DW-1:0]         best_d_in [NEIGHBOURS];
   logic [CW-1:0]         best_n_ff [NEIGHBOURS];
   logic [CW-1:0]         best_n_in [NEIGHBOURS];
   logic [NEIGHBOURS-1:0] best_v_ff;
   logic [NEIGHBOURS-1:0] best_v_in;
   logic [NEIGHBOURS-1:0] lt;
   logic [NEIGHBOURS-1:0] lt_prev;

   always_comb begin
      for (int k = 0; k < NEIGHBOURS; k++) begin
         lt[k] = v4_ff && (sum_ff < {2'b00, best_d_ff[k]});
      end
      lt_prev[0] = 1'b0;
      for (int k = 1; k < NEIGHBOURS; k++) begin
         lt_prev[k] = lt[k-1];
      end
   end

   always_comb begin
      for (int k = 0; k < NEIGHBOURS; k++) begin
         best_d_in[k] = best_d_ff[k];
         best_n_in[k] = best_n_ff[k];
         best_v_in[k] = best_v_ff[k];
      end
      for (int k = 0; k < NEIGHBOURS; k++) begin
         if (cmd.list_clear) begin
            best_d_in[k] = knps_pkg::LIMIT_SQ;
            best_n_in[k] = '0;
            best_v_in[k] = 1'b0;
         end else if (lt[k] && !lt_prev[k]) begin
            best_d_in[k] = sum_ff[DW-1:0];
            best_n_in[k] = j4_ff;
            best_v_in[k] = 1'b1;
         end
      end
      // Entries behind the insertion slot move one place toward the tail.
      for (int k = 1; k < NEIGHBOURS; k++) begin
         if (!cmd.list_clear && lt[k] && lt_prev[k]) begin
            best_d_in[k] = best_d_ff[k-1];
            best_n_in[k] = best_n_ff[k-1];
            best_v_in[k] = best_v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_v_ff <= '0;
      end else begin
         best_v_ff <= best_v_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NEIGHBOURS; k++) begin
         best_d_ff[k] <= best_d_in[k];
         best_n_ff[k] <= best_n_in[k];
      end
   end

   // Bit-serial integer square root, two radicand bits per step.
   logic [DW-1:0]    rad_ff, rad_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [TW-1:0]    root_ff, root_in;

   always_comb begin
      logic [REM_W+1:0] rem_next;
      logic [REM_W+1:0] trial;
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      rem_next = {rem_ff, rad_ff[DW-1:DW-2]};
      trial = {1'b0, root_ff, 2'b01};
      if (cmd.root_start) begin
         rad_in = best_d_ff[rank];
         rem_in = '0;
         root_in = '0;
      end else if (cmd.root_step) begin
         rad_in = {rad_ff[DW-3:0], 2'b00};
         if (rem_next >= trial) begin
            rem_in = REM_W'(rem_next - trial);
            root_in = {root_ff[TW-2:0], 1'b1};
         end else begin
            rem_in = REM_W'(rem_next);
            root_in = {root_ff[TW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
   end

   // Result word register.
   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         rsp_rank <= knps_pkg::RANK_W'(rank);
         rsp_found <= best_v_ff[rank];
         rsp_neighbour_index <= best_v_ff[rank] ?
            best_n_ff[rank][knps_pkg::INDEX_W-1:0] : '0;
         rsp_neighbour_distance <= best_v_ff[rank] ? root_ff : '0;
         rsp_last <= (rank == RW'(NEIGHBOURS - 1));
      end
   end

   assign status.pipe_empty = !(v1_ff || v2_ff || v3_ff || v4_ff);
   assign status.sel_found = best_v_ff[rank];

endmodule

`default_nettype wire

### hw/rtl/knps_ctrl.sv
// ----------------------------------------------------------------------------
// knps_ctrl
// Controller of the nearest point selection block: handshakes, the point
// count register, the scan and rank counters and the sequencing state machine.
// ----------------------------------------------------------------------------
`default_nettype none

module knps_ctrl #(
   parameter int MAX_POINTS = 1024,
   parameter int NEIGHBOURS = 6
) (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire logic                                         req_valid,
   output logic                                              req_ready,
   input  wire logic                                         req_opcode,
   input  wire logic [knps_pkg::INDEX_W-1:0]                 req_point_index,
   input  wire logic                                         csr_valid,
   output logic                                              csr_ready,
   input  wire logic [knps_pkg::COUNT_W-1:0]                 csr_point_count,
   output logic                                              rsp_valid,
   input  wire logic                                         rsp_ready,
   output knps_pkg::cmd_type                                 cmd,
   input  wire knps_pkg::status_type                         status,
   output logic [$clog2(MAX_POINTS)-1:0]                     mem_addr,
   output logic [knps_pkg::COUNT_W-1:0]                      scan_index,
   output logic [((NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1)-1:0] rank
);

   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int RW = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;
   localparam int CW = knps_pkg::COUNT_W;
   localparam int RCW = knps_pkg::ROOT_CNT_W;

   knps_pkg::state_type state_ff, state_in;

   logic [CW-1:0]                 csr_count_ff;
   logic [CW-1:0]                 count_ff, count_in;
   logic [knps_pkg::INDEX_W-1:0]  q_idx_ff, q_idx_in;
   logic [CW-1:0]                 j_ff, j_in;
   logic [RW-1:0]                 rank_ff, rank_in;
   logic [RCW-1:0]                root_cnt_ff, root_cnt_in;
   logic [CW-1:0]                 count_clamp;
   logic                          req_accept;
   logic                          is_query;
   logic                          query_in_range;
   logic                          load_in_range;
   logic                          scan_done;
   logic                          rank_done;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         csr_count_ff <= csr_point_count;
      end
   end

   assign count_clamp = (32'(csr_count_ff) > 32'(MAX_POINTS)) ?
      CW'(MAX_POINTS) : csr_count_ff;
   assign req_accept = req_valid && req_ready;
   assign is_query = (req_opcode == knps_pkg::OP_QUERY);
   assign query_in_range = ({1'b0, req_point_index} < count_clamp);
   assign load_in_range = (32'(req_point_index) < 32'(MAX_POINTS));
   assign scan_done = ((j_ff + CW'(1)) == count_ff);
   assign rank_done = (rank_ff == RW'(NEIGHBOURS - 1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         knps_pkg::ST_IDLE: begin
            if (req_valid && is_query) begin
               state_in = query_in_range ? knps_pkg::ST_QUERY_READ : knps_pkg::ST_RANK;
            end
         end
         knps_pkg::ST_QUERY_READ: begin
            state_in = knps_pkg::ST_QUERY_LATCH;
         end
         knps_pkg::ST_QUERY_LATCH: begin
            state_in = knps_pkg::ST_SCAN;
         end
         knps_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = knps_pkg::ST_DRAIN;
            end
         end
         knps_pkg::ST_DRAIN: begin
            if (status.pipe_empty) begin
               state_in = knps_pkg::ST_RANK;
            end
         end
         knps_pkg::ST_RANK: begin
            state_in = status.sel_found ? knps_pkg::ST_ROOT : knps_pkg::ST_RESULT_LOAD;
         end
         knps_pkg::ST_ROOT: begin
            if (root_cnt_ff == RCW'(knps_pkg::ROOT_STEPS - 1)) begin
               state_in = knps_pkg::ST_RESULT_LOAD;
            end
         end
         knps_pkg::ST_RESULT_LOAD: begin
            state_in = knps_pkg::ST_EMIT;
         end
         knps_pkg::ST_EMIT: begin
            if (rsp_ready) begin
               state_in = rank_done ? knps_pkg::ST_IDLE : knps_pkg::ST_RANK;
            end
         end
         default: begin
            state_in = knps_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         knps_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.mem_write = req_valid && !is_query && load_in_range;
            cmd.list_clear = req_valid && is_query;
         end
         knps_pkg::ST_QUERY_READ: begin
            cmd.mem_read = 1'b1;
         end
         knps_pkg::ST_QUERY_LATCH: begin
            cmd.query_latch = 1'b1;
         end
         knps_pkg::ST_SCAN: begin
            cmd.mem_read = 1'b1;
            cmd.scan_valid = (j_ff != {1'b0, q_idx_ff});
         end
         knps_pkg::ST_DRAIN: begin
         end
         knps_pkg::ST_RANK: begin
            cmd.root_start = status.sel_found;
         end
         knps_pkg::ST_ROOT: begin
            cmd.root_step = 1'b1;
         end
         knps_pkg::ST_RESULT_LOAD: begin
            cmd.result_load = 1'b1;
         end
         knps_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign mem_addr = (state_ff == knps_pkg::ST_QUERY_READ) ?
      ADDR_W'(q_idx_ff) : ADDR_W'(j_ff);
   assign scan_index = j_ff;
   assign rank = rank_ff;

   // Counters and query registers.
   always_comb begin
      count_in = count_ff;
      q_idx_in = q_idx_ff;
      j_in = j_ff;
      rank_in = rank_ff;
      root_cnt_in = root_cnt_ff;
      if (state_ff == knps_pkg::ST_IDLE && req_accept && is_query) begin
         count_in = count_clamp;
         q_idx_in = req_point_index;
         rank_in = '0;
      end
      if (state_ff == knps_pkg::ST_QUERY_LATCH) begin
         j_in = '0;
      end
      if (state_ff == knps_pkg::ST_SCAN) begin
         j_in = j_ff + CW'(1);
      end
      if (state_ff == knps_pkg::ST_RANK) begin
         root_cnt_in = '0;
      end
      if (state_ff == knps_pkg::ST_ROOT) begin
         root_cnt_in = root_cnt_ff + RCW'(1);
      end
      if (state_ff == knps_pkg::ST_EMIT && rsp_ready && !rank_done) begin
         rank_in = rank_ff + RW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= knps_pkg::ST_IDLE;
         count_ff <= '0;
         q_idx_ff <= '0;
         j_ff <= '0;
         rank_ff <= '0;
         root_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         q_idx_ff <= q_idx_in;
         j_ff <= j_in;
         rank_ff <= rank_in;
         root_cnt_ff <= root_cnt_in;
      end
   end

   a_one_side_open: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request and response sides open together");

   a_last_word_ends_query: assert property (@(posedge clock) disable iff (reset)
      (state_ff == knps_pkg::ST_EMIT && rsp_ready && rank_done)
      |=> (state_ff == knps_pkg::ST_IDLE))
      else $error("query did not end after its last word");

   a_scan_in_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == knps_pkg::ST_SCAN) |-> (j_ff < count_ff))
      else $error("scan index beyond point count");

   a_list_settled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == knps_pkg::ST_RANK) |-> status.pipe_empty)
      else $error("neighbour list read while distances still in flight");

endmodule

`default_nettype wire

### hw/rtl/k_nearest_point_select_top.sv
// ----------------------------------------------------------------------------
// k_nearest_point_select_top
// Keeps a store of 3-D Q2.14 points and returns, for a queried point, its
// nearest neighbours closer than 3.0, sorted by distance.
// ----------------------------------------------------------------------------
// Usage. The req channel takes one word per item. A load word (opcode 0)
// writes the coordinates into the store slot point_index; it gives no
// response. A query word (opcode 1) scans every stored point below
// point_count and answers with NEIGHBOURS words on the rsp channel, rank 0
// first, the last one flagged by rsp_last. Empty ranks come with found low.
// The csr channel writes point_count; it is always ready and should be written
// only while no query is in progress.
// A query first scans, reading one point per cycle through the one read port
// of the store; then, for each rank in turn, it runs the bit-serial square
// root if the rank holds a neighbour, loads the result word and emits it,
// held while the receiver keeps rsp_ready low. A query index out of range
// skips the scan. One item is worked on at a time; req_ready is high only
// while the block is idle. A stall on rsp holds the current word unchanged.
// Reset clears the controller and point_count; the store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module k_nearest_point_select_top #(
   parameter int MAX_POINTS = 1024,
   parameter int NEIGHBOURS = 6
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_opcode,
   input  wire logic [knps_pkg::INDEX_W-1:0]        req_point_index,
   input  wire logic signed [knps_pkg::COORD_W-1:0] req_coord_x,
   input  wire logic signed [knps_pkg::COORD_W-1:0] req_coord_y,
   input  wire logic signed [knps_pkg::COORD_W-1:0] req_coord_z,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [knps_pkg::COUNT_W-1:0]        csr_point_count,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [knps_pkg::RANK_W-1:0]              rsp_rank,
   output logic                                     rsp_found,
   output logic [knps_pkg::INDEX_W-1:0]             rsp_neighbour_index,
   output logic [knps_pkg::DIST_W-1:0]              rsp_neighbour_distance,
   output logic                                     rsp_last
);

   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int RW = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;

   knps_pkg::cmd_type              cmd;
   knps_pkg::status_type           status;
   logic [ADDR_W-1:0]              mem_addr;
   logic [knps_pkg::COUNT_W-1:0]   scan_index;
   logic [RW-1:0]                  rank;

   knps_ctrl #(
      .MAX_POINTS (MAX_POINTS),
      .NEIGHBOURS (NEIGHBOURS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_point_index (req_point_index),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_point_count (csr_point_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .cmd             (cmd),
      .status          (status),
      .mem_addr        (mem_addr),
      .scan_index      (scan_index),
      .rank            (rank)
   );

   knps_datapath #(
      .MAX_POINTS (MAX_POINTS),
      .NEIGHBOURS (NEIGHBOURS)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .mem_addr               (mem_addr),
      .scan_index             (scan_index),
      .rank                   (rank),
      .req_point_index        (req_point_index),
      .req_coord_x            (req_coord_x),
      .req_coord_y            (req_coord_y),
      .req_coord_z            (req_coord_z),
      .rsp_rank               (rsp_rank),
      .rsp_found              (rsp_found),
      .rsp_neighbour_index    (rsp_neighbour_index),
      .rsp_neighbour_distance (rsp_neighbour_distance),
      .rsp_last               (rsp_last)
   );

endmodule

`default_nettype wire
